### hdl/brb_pkg.sv
// Shared types and codes for the byte ring buffer FIFO.
// No dependencies; used by brb_ctrl and the top level.
package brb_pkg;

  // Operation selected by each input item
  typedef enum logic [2:0] {
    MODE_PUT     = 3'd0,
    MODE_GET     = 3'd1,
    MODE_AHEAD   = 3'd2,
    MODE_ADVANCE = 3'd3,
    MODE_FLUSH   = 3'd4
  } brb_mode_t;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIST_N  = 256;   // number of distance codes
  localparam logic [7:0]  SAT_MAX = 8'hFF;

  // Status of one item, handed from the pointer unit to the output side
  typedef struct packed {
    logic       done;
    logic [7:0] batch;
    logic [7:0] fill;
    logic [7:0] free;
    logic       empty;
    logic       full;
  } brb_status_t;

endpackage

### hdl/brb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### hdl/brb_ctrl.sv
// Pointer unit: read/write pointers, batch counter, memory requests, status.
// Depends on brb_pkg.
module brb_ctrl #(
  parameter int unsigned SLOTS = 256,
  parameter int unsigned PW    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [2:0]          mode,
  input  logic [7:0]          data_in,
  input  logic [7:0]          distance,
  input  logic                last_in,
  output logic                mem_we,
  output logic [PW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [PW-1:0]       mem_raddr,
  output logic                is_get,
  output brb_pkg::brb_status_t status
);

  localparam int unsigned CW = (PW > 8) ? PW : 8;
  localparam logic [PW-1:0] TOP   = PW'(SLOTS - 1);
  localparam logic [PW:0]   SLOTS_X = (PW+1)'(SLOTS);

  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [7:0]    batch_r, batch_nxt, total;
  logic [PW-1:0] dist_mod_tbl [brb_pkg::DIST_N];
  logic [PW-1:0] dist_mod, wp_inc, rp_inc, wp_off;
  logic [PW:0]   off_sum, diff;
  logic [PW-1:0] fill, free;
  logic [CW-1:0] fill_x, free_x;
  logic          full_now, empty_now, done;

  // Distance reduced modulo SLOTS, worked out at elaboration
  for (genvar g = 0; g < brb_pkg::DIST_N; g++) begin : g_dmod
    assign dist_mod_tbl[g] = PW'(g % SLOTS);
  end

  always_comb begin
    dist_mod  = dist_mod_tbl[distance];
    wp_inc    = (wp_r == TOP) ? '0 : wp_r + 1'b1;
    rp_inc    = (rp_r == TOP) ? '0 : rp_r + 1'b1;
    off_sum   = {1'b0, wp_r} + {1'b0, dist_mod};
    wp_off    = (off_sum >= SLOTS_X) ? PW'(off_sum - SLOTS_X) : off_sum[PW-1:0];
    full_now  = (wp_inc == rp_r);
    empty_now = (wp_r == rp_r);
  end

  // Operation decode
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    done      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = data_in;
    mem_re    = 1'b0;
    mem_raddr = rp_r;
    is_get    = 1'b0;
    unique case (brb_pkg::brb_mode_t'(mode))
      brb_pkg::MODE_PUT: begin
        if (!full_now) begin
          mem_we = go;
          wp_nxt = wp_inc;
          done   = 1'b1;
        end
      end
      brb_pkg::MODE_GET: begin
        is_get = 1'b1;
        if (!empty_now) begin
          mem_re = go;
          rp_nxt = rp_inc;
          done   = 1'b1;
        end
      end
      brb_pkg::MODE_AHEAD: begin
        mem_we    = go;
        mem_waddr = wp_off;
      end
      brb_pkg::MODE_ADVANCE: begin
        wp_nxt = wp_off;
      end
      brb_pkg::MODE_FLUSH: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Batch count and status after the item
  always_comb begin
    total     = (done && batch_r != brb_pkg::SAT_MAX) ? batch_r + 1'b1 : batch_r;
    batch_nxt = last_in ? '0 : total;
    diff      = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    fill      = diff[PW] ? PW'(diff + SLOTS_X) : diff[PW-1:0];
    free      = TOP - fill;
    fill_x    = CW'(fill);
    free_x    = CW'(free);
    status.done  = done;
    status.batch = total;
    status.fill  = (fill_x > CW'(255)) ? brb_pkg::SAT_MAX : fill_x[7:0];
    status.free  = (free_x > CW'(255)) ? brb_pkg::SAT_MAX : free_x[7:0];
    status.empty = (wp_nxt == rp_nxt);
    status.full  = (((wp_nxt == TOP) ? '0 : wp_nxt + 1'b1) == rp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      batch_r <= '0;
    end else if (go) begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      batch_r <= batch_nxt;
    end
  end

endmodule

### hdl/byte_ring_buffer_fifo_top.sv
// Top level of the byte ring buffer FIFO: stream ports, store clearing, result registers.
// Depends on brb_pkg, brb_ram and brb_ctrl.
//
// A byte FIFO of SLOTS entries that always leaves one entry empty, so it holds
// at most SLOTS-1 bytes. Each input transfer carries one operation (put, get,
// write ahead of the write pointer, advance the write pointer, flush) and
// yields exactly one result transfer with the byte read, a done flag, the
// running batch total (reset after a transfer with tlast) and the fill/free
// counts plus empty/full flags after the operation. The byte store is one
// synchronous RAM; after reset the block walks it and zeroes one entry per
// cycle, and in_tready stays low until every entry is cleared. From then
// on an item is accepted every cycle while results drain: the pointer update
// and the RAM access happen on the accepting edge, the RAM's registered read
// puts the item in a pending stage, and it moves from there into the output
// register once that register is empty or drains. With the output stalled,
// one item waits there and one in the pending stage, and in_tready drops.
module byte_ring_buffer_fifo_top #(
  parameter int unsigned SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[2:0], data_in[10:3], distance[18:11], zero pad
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // data_out[7:0], done_res[8], batch_total[16:9],
                                  // fill_count[24:17], free_count[32:25],
                                  // is_empty[33], is_full[34], zero pad
);

  localparam int unsigned PW = $clog2(SLOTS);
  localparam logic [PW-1:0] TOP = PW'(SLOTS - 1);

  // Store clearing sweep
  logic          clr_r, clr_nxt;
  logic [PW-1:0] clr_addr_r, clr_addr_nxt;

  // Pending stage (waits for RAM read data) and output register
  logic                 pend_r, pend_nxt;
  logic                 pend_get_r;
  brb_pkg::brb_status_t pend_st_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [39:0]          out_data_r;

  logic                 accept, pend_move;
  brb_pkg::brb_status_t st;
  logic                 is_get;
  logic                 c_we, c_re;
  logic [PW-1:0]        c_waddr, c_raddr;
  logic [7:0]           c_wdata, rdata, rd_byte;
  logic                 ram_we;
  logic [PW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;

  // Pending item may advance when the output register is empty or drains now
  assign pend_move = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_r && (!pend_r || pend_move);
  assign accept    = in_tvalid && in_tready;

  brb_ctrl #(
    .SLOTS (SLOTS),
    .PW    (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .mode      (in_tdata[2:0]),
    .data_in   (in_tdata[10:3]),
    .distance  (in_tdata[18:11]),
    .last_in   (in_tlast),
    .mem_we    (c_we),
    .mem_waddr (c_waddr),
    .mem_wdata (c_wdata),
    .mem_re    (c_re),
    .mem_raddr (c_raddr),
    .is_get    (is_get),
    .status    (st)
  );

  // Clearing sweep owns the write port until it finishes
  always_comb begin
    ram_we    = clr_r ? 1'b1 : c_we;
    ram_waddr = clr_r ? clr_addr_r : c_waddr;
    ram_wdata = clr_r ? '0 : c_wdata;
  end

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (rdata)
  );

  always_comb begin
    clr_nxt      = clr_r && (clr_addr_r != TOP);
    clr_addr_nxt = clr_r ? clr_addr_r + 1'b1 : clr_addr_r;
    pend_nxt     = accept || (pend_r && !pend_move);
    out_valid_nxt = pend_move || (out_valid_r && !out_tready);
    // A get that found the buffer empty reports zero
    rd_byte      = (pend_get_r && pend_st_r.done) ? rdata : '0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: capture status on accept, assemble the result on the move
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_get_r <= is_get;
      pend_st_r  <= st;
    end
    if (pend_move) begin
      out_data_r <= {5'b0, pend_st_r.full, pend_st_r.empty, pend_st_r.free,
                     pend_st_r.fill, pend_st_r.batch, pend_st_r.done, rd_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### bench/byte_ring_buffer_fifo_top_tb.sv
// Self-checking bench for byte_ring_buffer_fifo_top: drives put, get, write-ahead,
// advance, flush and spare-mode transfers and compares each result transfer with
// a shadow ring buffer kept in the bench. Depends on brb_pkg and the RTL only.
module byte_ring_buffer_fifo_top_tb;

  localparam int unsigned RING_SLOTS   = 256;
  localparam int unsigned ITEM_TARGET  = 1500;
  localparam int unsigned SATURATED    = 255;
  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned WATCHDOG_CYC = 600000;
  // Mode codes the block leaves unused; they must act as a no-op
  localparam logic [2:0]  MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0]  MODE_SPARE_MID = 3'd6;
  localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;

  // One result transfer, fields in the order the block reports them
  typedef struct packed {
    logic [7:0] rd_byte;
    logic       done;
    logic [7:0] batch;
    logic [7:0] fill;
    logic [7:0] free;
    logic       empty;
    logic       full;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // mode[2:0], data_in[10:3], distance[18:11], zero pad
  logic        in_tlast = 1'b0;  // last_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // data_out[7:0], done_res[8], batch_total[16:9],
                                 // fill_count[24:17], free_count[32:25],
                                 // is_empty[33], is_full[34], zero pad

  // Shadow ring buffer: predicts each result and checks what the block returns
  class brb_ring_checker;
    logic [7:0]   shadow_store [RING_SLOTS];
    int unsigned  wr_pos;
    int unsigned  rd_pos;
    int unsigned  batch_cnt;
    ring_result_t pending_results [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  puts_refused;
    int unsigned  gets_empty;
    int unsigned  bytes_moved;

    function new();
      foreach (shadow_store[k]) shadow_store[k] = 8'h00;
      wr_pos = 0;
      rd_pos = 0;
      batch_cnt = 0;
      mismatches = 0;
      checked = 0;
      puts_refused = 0;
      gets_empty = 0;
      bytes_moved = 0;
    endfunction

    function int unsigned clip8(int unsigned v);
      return (v > SATURATED) ? SATURATED : v;
    endfunction

    // Apply one accepted input transfer and queue the result it must produce
    function void note_transfer(logic [2:0] op, logic [7:0] byte_val, logic [7:0] offset,
                                logic last_flag);
      ring_result_t res;
      int unsigned  fill;
      res = '0;
      case (op)
        brb_pkg::MODE_PUT: begin
          if ((wr_pos + 1) % RING_SLOTS != rd_pos) begin
            shadow_store[wr_pos] = byte_val;
            wr_pos = (wr_pos + 1) % RING_SLOTS;
            res.done = 1'b1;
          end else begin
            puts_refused++;
          end
        end
        brb_pkg::MODE_GET: begin
          if (wr_pos != rd_pos) begin
            res.rd_byte = shadow_store[rd_pos];
            rd_pos = (rd_pos + 1) % RING_SLOTS;
            res.done = 1'b1;
          end else begin
            gets_empty++;
          end
        end
        brb_pkg::MODE_AHEAD:
          shadow_store[(wr_pos + offset % RING_SLOTS) % RING_SLOTS] = byte_val;
        brb_pkg::MODE_ADVANCE: wr_pos = (wr_pos + offset % RING_SLOTS) % RING_SLOTS;
        brb_pkg::MODE_FLUSH: begin
          wr_pos = 0;
          rd_pos = 0;
        end
        default: ;
      endcase
      if (res.done) begin
        bytes_moved++;
        if (batch_cnt < SATURATED) batch_cnt++;
      end
      res.batch = batch_cnt[7:0];
      if (last_flag) batch_cnt = 0;
      fill = (wr_pos + RING_SLOTS - rd_pos) % RING_SLOTS;
      res.fill  = 8'(clip8(fill));
      res.free  = 8'(clip8(RING_SLOTS - 1 - fill));
      res.empty = (wr_pos == rd_pos);
      res.full  = ((wr_pos + 1) % RING_SLOTS == rd_pos);
      pending_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_transfer(logic [39:0] word);
      ring_result_t seen;
      ring_result_t want;
      seen.rd_byte = word[7:0];
      seen.done    = word[8];
      seen.batch   = word[16:9];
      seen.fill    = word[24:17];
      seen.free    = word[32:25];
      seen.empty   = word[33];
      seen.full    = word[34];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result transfer %h with nothing pending", $realtime, word);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result %0d: exp byte %h done %b batch %0d fill %0d free %0d e/f %b%b",
                    "\n           got byte %h done %b batch %0d fill %0d free %0d e/f %b%b"},
                   $realtime, checked, want.rd_byte, want.done, want.batch, want.fill,
                   want.free, want.empty, want.full,
                   seen.rd_byte, seen.done, seen.batch, seen.fill, seen.free,
                   seen.empty, seen.full);
      end
    endfunction
  endclass

  brb_ring_checker ring_chk;
  int unsigned     items_sent = 0;
  bit              calm = 1'b0;   // phase with no idling on either side

  byte_ring_buffer_fifo_top #(
    .SLOTS(RING_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock and a single reset pulse at the start of the run
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: covers the store clearing pass plus the slowest legal pacing many times over
  initial begin
    #(2 * CLK_HALF * WATCHDOG_CYC);
    $display("TB_ERROR");
    $finish;
  end

  // Random field values at their exact widths
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Pause length in cycles: mostly none, some short, a few long; none in calm phases
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until the block takes it, then record the prediction.
  // in_tvalid is only dropped when a gap is chosen, so back-to-back items keep it high.
  task automatic drive_op(input logic [2:0] op, input logic [7:0] byte_val,
                          input logic [7:0] offset, input logic last_flag);
    int unsigned gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, offset, byte_val, op};
    in_tlast  <= last_flag;
    do @(posedge clk); while (in_tready !== 1'b1);
    ring_chk.note_transfer(op, byte_val, offset, last_flag);
    items_sent++;
  endtask

  // Result side: check every completed transfer, then choose the next tready level
  initial begin
    int unsigned stall_left;
    int unsigned n;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) ring_chk.check_transfer(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        n = pick_pause();
        if (n > 0) begin
          out_tready <= 1'b0;
          stall_left = n - 1;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Stimulus: directed corners, a full fill/drain batch, then random phases
  initial begin
    int unsigned k;
    int unsigned len;
    ring_chk = new();
    do @(posedge clk); while (rst_n !== 1'b1);

    // Empty get, extreme bytes in and out, batch closed by tlast
    drive_op(brb_pkg::MODE_GET,     8'h00, 8'h00, 1'b0);
    drive_op(brb_pkg::MODE_PUT,     8'h00, 8'hFF, 1'b0);
    drive_op(brb_pkg::MODE_PUT,     8'hFF, 8'h00, 1'b1);
    drive_op(brb_pkg::MODE_GET,     8'h00, 8'h00, 1'b0);
    drive_op(brb_pkg::MODE_GET,     8'hFF, 8'hFF, 1'b1);
    drive_op(brb_pkg::MODE_GET,     8'h00, 8'h00, 1'b1);
    // Write ahead at the nearest and farthest distance, advance by zero
    drive_op(brb_pkg::MODE_AHEAD,   8'hA5, 8'h00, 1'b0);
    drive_op(brb_pkg::MODE_AHEAD,   8'h5A, 8'hFF, 1'b0);
    drive_op(brb_pkg::MODE_ADVANCE, 8'h00, 8'h00, 1'b0);
    drive_op(brb_pkg::MODE_PUT,     8'h3C, 8'h00, 1'b0);
    drive_op(brb_pkg::MODE_FLUSH,   8'hFF, 8'hFF, 1'b0);
    // Advance straight to full, then a put that must be dropped
    drive_op(brb_pkg::MODE_ADVANCE, 8'h00, 8'hFF, 1'b0);
    drive_op(brb_pkg::MODE_PUT,     8'h77, 8'h00, 1'b1);
    // Overwrite unread data ahead of the pointer, read it back
    drive_op(brb_pkg::MODE_AHEAD,   8'hC3, 8'h01, 1'b0);
    drive_op(brb_pkg::MODE_GET,     8'h00, 8'h00, 1'b0);
    // Advance past the read pointer
    drive_op(brb_pkg::MODE_ADVANCE, 8'h00, 8'h80, 1'b0);
    // Spare modes are no-ops that still report status
    drive_op(MODE_SPARE_LO,  8'hFF, 8'hFF, 1'b1);
    drive_op(MODE_SPARE_MID, 8'h00, 8'h00, 1'b0);
    drive_op(MODE_SPARE_HI,  8'h55, 8'hAA, 1'b1);
    drive_op(brb_pkg::MODE_FLUSH,   8'h00, 8'h00, 1'b1);

    // Fill to full past the point of refusal, then drain past empty in one long
    // batch so the batch total saturates
    drive_op(brb_pkg::MODE_FLUSH, 8'h00, 8'h00, 1'b1);
    for (k = 0; k < RING_SLOTS + 4; k++)
      drive_op(brb_pkg::MODE_PUT, rand_byte(), rand_byte(), 1'b0);
    for (k = 0; k < RING_SLOTS + 4; k++)
      drive_op(brb_pkg::MODE_GET, rand_byte(), rand_byte(), k == RING_SLOTS + 3);

    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // bulk put: a run of single-byte puts closed by tlast
          len = $urandom_range(1, 48);
          for (k = 0; k < len; k++)
            drive_op(brb_pkg::MODE_PUT, rand_byte(), rand_byte(), k == len - 1);
        end
        3, 4, 5: begin
          // bulk get: same shape on the read side
          len = $urandom_range(1, 48);
          for (k = 0; k < len; k++)
            drive_op(brb_pkg::MODE_GET, rand_byte(), rand_byte(), k == len - 1);
        end
        6, 7: begin
          // reserve by writing ahead, then commit with one advance
          len = $urandom_range(1, 16);
          for (k = 0; k < len; k++)
            drive_op(brb_pkg::MODE_AHEAD, rand_byte(), 8'(k), 1'b0);
          drive_op(brb_pkg::MODE_ADVANCE, rand_byte(), 8'(len), rand_bit());
        end
        8: begin
          // noise: any mode, any field values
          len = $urandom_range(1, 20);
          for (k = 0; k < len; k++)
            drive_op(3'($urandom_range(0, MODE_SPARE_HI)), rand_byte(),
                     rand_byte(), rand_bit());
        end
        default: drive_op(brb_pkg::MODE_FLUSH, rand_byte(), rand_byte(), rand_bit());
      endcase
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain outstanding predictions, then allow a few cycles for stray results
    while (ring_chk.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d transfers; %0d results checked, %0d bytes moved.",
             items_sent, ring_chk.checked, ring_chk.bytes_moved);
    $display("Refused puts %0d, gets on empty %0d, mismatches %0d.",
             ring_chk.puts_refused, ring_chk.gets_empty, ring_chk.mismatches);
    if (ring_chk.mismatches == 0 && ring_chk.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### byte_ring_buffer_fifo_top.f
hdl/brb_pkg.sv
hdl/brb_ram.sv
hdl/brb_ctrl.sv
hdl/byte_ring_buffer_fifo_top.sv
bench/byte_ring_buffer_fifo_top_tb.sv
